FILE: rtl/cross_neighbour_pixel_blend_defines.svh
// Assertion macros for the cross-neighbour pixel blend checker.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef CROSS_NEIGHBOUR_PIXEL_BLEND_DEFINES_SVH
`define CROSS_NEIGHBOUR_PIXEL_BLEND_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define CNPB_ASSERT_IMPLIES(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cnpb check failed");

// Next-cycle implication, disabled while in reset.
`define CNPB_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cnpb check failed");

`endif

FILE: rtl/cnpb_pkg.sv
// Shared constants, codes and controller/datapath interface types for the
// cross-neighbour pixel blend. No dependencies.
package cnpb_pkg;

    localparam int MAX_WIDTH_DEF    = 1024;
    localparam int MAX_HEIGHT_DEF   = 1024;
    localparam int CHANNEL_BITS_DEF = 16;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 11;
    localparam int POS_BITS       = 10;

    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_WIDTH  = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_FRAME_HEIGHT = CFG_INDEX_BITS'(1);

    localparam logic [CFG_DATA_BITS-1:0] FRAME_SIZE_RESET = CFG_DATA_BITS'(1024);

    // line store read phases
    localparam logic [1:0] PH_A = 2'd0;
    localparam logic [1:0] PH_B = 2'd1;
    localparam logic [1:0] PH_C = 2'd2;

    // result slots of one input word
    localparam logic [1:0] SLOT_UP   = 2'd0;
    localparam logic [1:0] SLOT_LEFT = 2'd1;
    localparam logic [1:0] SLOT_LAST = 2'd2;

    typedef struct packed {
        logic       take;
        logic       rd_en;
        logic [1:0] rd_phase;
        logic       cap_en;
        logic [1:0] cap_phase;
        logic       wr_en;
        logic       sum_en;
        logic [1:0] slot;
        logic       div_en;
        logic       out_load;
        logic       last;
    } cnpb_cmd_t;

    typedef struct packed {
        logic [2:0] emit_mask;
        logic       out_free;
    } cnpb_status_t;

endpackage

FILE: rtl/cnpb_ctrl.sv
// Sequencer for the cross-neighbour pixel blend: read, capture, store and
// emit steps per input word. Depends on cnpb_pkg.
module cnpb_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  cnpb_pkg::cnpb_status_t  status,
    output cnpb_pkg::cnpb_cmd_t     cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD0  = 3'd1;
    localparam logic [2:0] ST_RD1  = 3'd2;
    localparam logic [2:0] ST_RD2  = 3'd3;
    localparam logic [2:0] ST_CAP  = 3'd4;
    localparam logic [2:0] ST_SUM  = 3'd5;
    localparam logic [2:0] ST_DIV  = 3'd6;
    localparam logic [2:0] ST_OUT  = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [2:0] mask_reg;
    logic [2:0] mask_next;
    logic [2:0] low_bit;
    logic [2:0] mask_rest;
    logic [1:0] slot;

    always_comb
    begin
        low_bit   = mask_reg & (~mask_reg + 3'd1);
        mask_rest = mask_reg & ~low_bit;
        if (mask_reg[0])
        begin
            slot = cnpb_pkg::SLOT_UP;
        end
        else if (mask_reg[1])
        begin
            slot = cnpb_pkg::SLOT_LEFT;
        end
        else
        begin
            slot = cnpb_pkg::SLOT_LAST;
        end
    end

    always_comb
    begin
        cmd           = '0;
        cmd.rd_phase  = cnpb_pkg::PH_A;
        cmd.cap_phase = cnpb_pkg::PH_A;
        cmd.slot      = slot;
        state_next    = state_reg;
        mask_next     = mask_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take   = 1'b1;
                    state_next = ST_RD0;
                end
            end
            ST_RD0:
            begin
                cmd.rd_en    = 1'b1;
                cmd.rd_phase = cnpb_pkg::PH_A;
                state_next   = ST_RD1;
            end
            ST_RD1:
            begin
                cmd.rd_en     = 1'b1;
                cmd.rd_phase  = cnpb_pkg::PH_B;
                cmd.cap_en    = 1'b1;
                cmd.cap_phase = cnpb_pkg::PH_A;
                state_next    = ST_RD2;
            end
            ST_RD2:
            begin
                cmd.rd_en     = 1'b1;
                cmd.rd_phase  = cnpb_pkg::PH_C;
                cmd.cap_en    = 1'b1;
                cmd.cap_phase = cnpb_pkg::PH_B;
                state_next    = ST_CAP;
            end
            ST_CAP:
            begin
                cmd.cap_en    = 1'b1;
                cmd.cap_phase = cnpb_pkg::PH_C;
                cmd.wr_en     = 1'b1;
                mask_next     = status.emit_mask;
                state_next    = (status.emit_mask == 3'd0) ? ST_IDLE : ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum_en = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_en = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.last     = (mask_rest == 3'd0);
                    mask_next    = mask_rest;
                    state_next   = (mask_rest == 3'd0) ? ST_IDLE : ST_SUM;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mask_reg  <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            mask_reg  <= mask_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

endmodule

FILE: rtl/cnpb_datapath.sv
// Datapath of the cross-neighbour pixel blend: frame registers, position
// counters, two line stores, blend arithmetic and output register.
// Depends on cnpb_pkg; driven by cnpb_ctrl commands.
module cnpb_datapath #(
    parameter int MAX_WIDTH    = cnpb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT   = cnpb_pkg::MAX_HEIGHT_DEF,
    parameter int CHANNEL_BITS = cnpb_pkg::CHANNEL_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cnpb_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [cnpb_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic [CHANNEL_BITS-1:0]             red_in,
    input  logic [CHANNEL_BITS-1:0]             green_in,
    input  logic [CHANNEL_BITS-1:0]             blue_in,
    input  cnpb_pkg::cnpb_cmd_t                 cmd,
    output cnpb_pkg::cnpb_status_t              status,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [CHANNEL_BITS-1:0]             red_out,
    output logic [CHANNEL_BITS-1:0]             green_out,
    output logic [CHANNEL_BITS-1:0]             blue_out,
    output logic [cnpb_pkg::POS_BITS-1:0]       out_row,
    output logic [cnpb_pkg::POS_BITS-1:0]       out_col,
    output logic                                last_of_run
);

    localparam int CB = CHANNEL_BITS;
    localparam int PW = 3 * CB;
    localparam int SW = CB + 2;
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WB = $clog2(MAX_WIDTH + 1);
    localparam int HB = $clog2(MAX_HEIGHT + 1);
    localparam int DIV3_SHIFT = CB + 4;
    localparam int MW = DIV3_SHIFT - 1;
    localparam int PRW = SW + MW;
    localparam logic [MW-1:0] DIV3_MULT = MW'(((1 << DIV3_SHIFT) + 2) / 3);

    logic [cnpb_pkg::CFG_DATA_BITS-1:0] frame_width_reg;
    logic [cnpb_pkg::CFG_DATA_BITS-1:0] frame_height_reg;
    logic [WB-1:0] width_eff;
    logic [HB-1:0] height_eff;

    logic [CW-1:0] col_pos_reg;
    logic [RW-1:0] row_pos_reg;
    logic          col_last;
    logic          row_last;

    logic [PW-1:0] px_reg;
    logic [CW-1:0] item_c_reg;
    logic [RW-1:0] item_r_reg;
    logic          item_col_last_reg;
    logic          item_row_last_reg;

    logic [PW-1:0] store_even [MAX_WIDTH];
    logic [PW-1:0] store_odd  [MAX_WIDTH];
    logic [PW-1:0] rd_even_reg;
    logic [PW-1:0] rd_odd_reg;
    logic [CW-1:0] prev_addr;
    logic [CW-1:0] cur_addr;
    logic [CW-1:0] even_addr;
    logic [CW-1:0] odd_addr;
    logic [PW-1:0] prev_rd;
    logic [PW-1:0] cur_rd;

    logic [PW-1:0] p_left_reg;
    logic [PW-1:0] p_mid_reg;
    logic [PW-1:0] p_right_reg;
    logic [PW-1:0] c_mid_reg;
    logic [PW-1:0] c_l1_reg;
    logic [PW-1:0] c_l2_reg;

    logic          r_ge1;
    logic          r_ge2;
    logic          c_ge1;
    logic          c_ge2;

    logic [PW-1:0] op [4];
    logic [3:0]    op_en;
    logic [PW-1:0] centre_sel;
    logic [SW-1:0] sum_comb [3];
    logic [2:0]    cnt_comb;

    logic [1:0]    slot_reg;
    logic [PW-1:0] centre_reg;
    logic [SW-1:0] sum_reg [3];
    logic [2:0]    cnt_reg;
    logic [PRW-1:0] prod [3];
    logic [CB-1:0] avg_reg [3];
    logic [CB:0]   blend_sum [3];
    logic [PW-1:0] blend;

    logic [RW-1:0] row_sel;
    logic [CW-1:0] col_sel;

    logic                          out_valid_reg;
    logic [PW-1:0]                 out_pix_reg;
    logic [cnpb_pkg::POS_BITS-1:0] out_row_reg;
    logic [cnpb_pkg::POS_BITS-1:0] out_col_reg;
    logic                          out_last_reg;

    // effective frame size
    always_comb
    begin
        if (frame_width_reg == '0)
        begin
            width_eff = WB'(1);
        end
        else if (int'(frame_width_reg) > MAX_WIDTH)
        begin
            width_eff = WB'(MAX_WIDTH);
        end
        else
        begin
            width_eff = WB'(frame_width_reg);
        end
        if (frame_height_reg == '0)
        begin
            height_eff = HB'(1);
        end
        else if (int'(frame_height_reg) > MAX_HEIGHT)
        begin
            height_eff = HB'(MAX_HEIGHT);
        end
        else
        begin
            height_eff = HB'(frame_height_reg);
        end
    end

    assign col_last  = ((WB'(col_pos_reg) + WB'(1)) == width_eff);
    assign row_last  = ((HB'(row_pos_reg) + HB'(1)) == height_eff);
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= cnpb_pkg::FRAME_SIZE_RESET;
            frame_height_reg <= cnpb_pkg::FRAME_SIZE_RESET;
            col_pos_reg      <= '0;
            row_pos_reg      <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                cnpb_pkg::REG_FRAME_WIDTH:
                begin
                    frame_width_reg <= cfg_data;
                    col_pos_reg     <= '0;
                    row_pos_reg     <= '0;
                end
                cnpb_pkg::REG_FRAME_HEIGHT:
                begin
                    frame_height_reg <= cfg_data;
                    col_pos_reg      <= '0;
                    row_pos_reg      <= '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.take)
        begin
            if (col_last)
            begin
                col_pos_reg <= '0;
                row_pos_reg <= row_last ? '0 : row_pos_reg + RW'(1);
            end
            else
            begin
                col_pos_reg <= col_pos_reg + CW'(1);
            end
        end
    end

    // latch the input word and its position
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            px_reg            <= {blue_in, green_in, red_in};
            item_c_reg        <= col_pos_reg;
            item_r_reg        <= row_pos_reg;
            item_col_last_reg <= col_last;
            item_row_last_reg <= row_last;
        end
    end

    assign r_ge1 = (item_r_reg != '0);
    assign r_ge2 = (item_r_reg > RW'(1));
    assign c_ge1 = (item_c_reg != '0);
    assign c_ge2 = (item_c_reg > CW'(1));

    assign status.emit_mask = {item_row_last_reg && item_col_last_reg,
                               item_row_last_reg && c_ge1,
                               r_ge1};
    assign status.out_free  = !out_valid_reg || !out_stall;

    // line store addressing
    always_comb
    begin
        case (cmd.rd_phase)
            cnpb_pkg::PH_A:
            begin
                prev_addr = item_c_reg - CW'(1);
                cur_addr  = item_c_reg;
            end
            cnpb_pkg::PH_B:
            begin
                prev_addr = item_c_reg;
                cur_addr  = item_c_reg - CW'(1);
            end
            cnpb_pkg::PH_C:
            begin
                prev_addr = item_c_reg + CW'(1);
                cur_addr  = item_c_reg - CW'(2);
            end
            default:
            begin
                prev_addr = item_c_reg;
                cur_addr  = item_c_reg;
            end
        endcase
        even_addr = item_r_reg[0] ? prev_addr : cur_addr;
        odd_addr  = item_r_reg[0] ? cur_addr : prev_addr;
        prev_rd   = item_r_reg[0] ? rd_even_reg : rd_odd_reg;
        cur_rd    = item_r_reg[0] ? rd_odd_reg : rd_even_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && !item_r_reg[0])
        begin
            store_even[item_c_reg] <= px_reg;
        end
        if (cmd.rd_en)
        begin
            rd_even_reg <= store_even[even_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && item_r_reg[0])
        begin
            store_odd[item_c_reg] <= px_reg;
        end
        if (cmd.rd_en)
        begin
            rd_odd_reg <= store_odd[odd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_en)
        begin
            case (cmd.cap_phase)
                cnpb_pkg::PH_A:
                begin
                    p_left_reg <= prev_rd;
                    c_mid_reg  <= cur_rd;
                end
                cnpb_pkg::PH_B:
                begin
                    p_mid_reg <= prev_rd;
                    c_l1_reg  <= cur_rd;
                end
                cnpb_pkg::PH_C:
                begin
                    p_right_reg <= prev_rd;
                    c_l2_reg    <= cur_rd;
                end
                default:
                begin
                end
            endcase
        end
    end

    // neighbour selection and sum
    always_comb
    begin
        op[0]      = px_reg;
        op[1]      = px_reg;
        op[2]      = px_reg;
        op[3]      = px_reg;
        op_en      = 4'd0;
        centre_sel = px_reg;
        case (cmd.slot)
            cnpb_pkg::SLOT_UP:
            begin
                op[0]      = c_mid_reg;
                op[1]      = px_reg;
                op[2]      = p_left_reg;
                op[3]      = p_right_reg;
                op_en      = {!item_col_last_reg, c_ge1, 1'b1, r_ge2};
                centre_sel = p_mid_reg;
            end
            cnpb_pkg::SLOT_LEFT:
            begin
                op[0]      = p_left_reg;
                op[1]      = c_l2_reg;
                op[2]      = px_reg;
                op_en      = {1'b0, 1'b1, c_ge2, r_ge1};
                centre_sel = c_l1_reg;
            end
            cnpb_pkg::SLOT_LAST:
            begin
                op[0]      = p_mid_reg;
                op[1]      = c_l1_reg;
                op_en      = {1'b0, 1'b0, c_ge1, r_ge1};
                centre_sel = px_reg;
            end
            default:
            begin
            end
        endcase
        cnt_comb = 3'(op_en[0]) + 3'(op_en[1]) + 3'(op_en[2]) + 3'(op_en[3]);
        for (int ch = 0; ch < 3; ch++)
        begin
            sum_comb[ch] = (op_en[0] ? SW'(op[0][ch*CB +: CB]) : SW'(0))
                         + (op_en[1] ? SW'(op[1][ch*CB +: CB]) : SW'(0))
                         + (op_en[2] ? SW'(op[2][ch*CB +: CB]) : SW'(0))
                         + (op_en[3] ? SW'(op[3][ch*CB +: CB]) : SW'(0));
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sum_en)
        begin
            slot_reg   <= cmd.slot;
            centre_reg <= centre_sel;
            cnt_reg    <= cnt_comb;
            for (int ch = 0; ch < 3; ch++)
            begin
                sum_reg[ch] <= sum_comb[ch];
            end
        end
    end

    // divide by the neighbour count
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            prod[ch] = PRW'(sum_reg[ch]) * PRW'(DIV3_MULT);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_en)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                case (cnt_reg)
                    3'd1:    avg_reg[ch] <= sum_reg[ch][CB-1:0];
                    3'd2:    avg_reg[ch] <= sum_reg[ch][CB:1];
                    3'd3:    avg_reg[ch] <= prod[ch][DIV3_SHIFT +: CB];
                    3'd4:    avg_reg[ch] <= sum_reg[ch][CB+1:2];
                    default: avg_reg[ch] <= centre_reg[ch*CB +: CB];
                endcase
            end
        end
    end

    // blend with centre and position of the result
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            blend_sum[ch]          = (CB+1)'(avg_reg[ch]) + (CB+1)'(centre_reg[ch*CB +: CB]);
            blend[ch*CB +: CB]     = blend_sum[ch][CB:1];
        end
        case (slot_reg)
            cnpb_pkg::SLOT_UP:
            begin
                row_sel = item_r_reg - RW'(1);
                col_sel = item_c_reg;
            end
            cnpb_pkg::SLOT_LEFT:
            begin
                row_sel = item_r_reg;
                col_sel = item_c_reg - CW'(1);
            end
            default:
            begin
                row_sel = item_r_reg;
                col_sel = item_c_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_pix_reg  <= blend;
            out_row_reg  <= cnpb_pkg::POS_BITS'(row_sel);
            out_col_reg  <= cnpb_pkg::POS_BITS'(col_sel);
            out_last_reg <= cmd.last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign red_out     = out_pix_reg[0 +: CB];
    assign green_out   = out_pix_reg[CB +: CB];
    assign blue_out    = out_pix_reg[2*CB +: CB];
    assign out_row     = out_row_reg;
    assign out_col     = out_col_reg;
    assign last_of_run = out_last_reg;

endmodule

FILE: rtl/cross_neighbour_pixel_blend.sv
// Top level of the cross-neighbour pixel blend: sequencer plus datapath.
// Depends on cnpb_pkg, cnpb_ctrl and cnpb_datapath.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_stall  | red_in, green_in, blue_in
//  out     | out_valid / out_stall| red_out, green_out, blue_out, out_row,
//          |                      | out_col, last_of_run
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data (always ready)
//
// A word yields n results (0 to 3) and also waits on output stalls: the
// sequencer makes three reads of each single-port line store, then sums,
// divides and blends each result in turn through one shared unit.
// Reset clears the frame registers to 1024x1024 and the position to (0,0);
// line stores need no clearing pass.
// A held output word stalls the sequencer only when the next result is due.
module cross_neighbour_pixel_blend #(
    parameter int MAX_WIDTH    = cnpb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT   = cnpb_pkg::MAX_HEIGHT_DEF,
    parameter int CHANNEL_BITS = cnpb_pkg::CHANNEL_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [CHANNEL_BITS-1:0]             red_in,
    input  logic [CHANNEL_BITS-1:0]             green_in,
    input  logic [CHANNEL_BITS-1:0]             blue_in,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [CHANNEL_BITS-1:0]             red_out,
    output logic [CHANNEL_BITS-1:0]             green_out,
    output logic [CHANNEL_BITS-1:0]             blue_out,
    output logic [cnpb_pkg::POS_BITS-1:0]       out_row,
    output logic [cnpb_pkg::POS_BITS-1:0]       out_col,
    output logic                                last_of_run,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cnpb_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [cnpb_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

    cnpb_pkg::cnpb_cmd_t    cmd;
    cnpb_pkg::cnpb_status_t status;

    cnpb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    cnpb_datapath #(
        .MAX_WIDTH    (MAX_WIDTH),
        .MAX_HEIGHT   (MAX_HEIGHT),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .red_in      (red_in),
        .green_in    (green_in),
        .blue_in     (blue_in),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .red_out     (red_out),
        .green_out   (green_out),
        .blue_out    (blue_out),
        .out_row     (out_row),
        .out_col     (out_col),
        .last_of_run (last_of_run)
    );

endmodule

FILE: rtl/cnpb_checker.sv
// Port-level checks for the cross-neighbour pixel blend, bound to the top.
// Depends on cnpb_pkg and cross_neighbour_pixel_blend_defines.svh.
`include "cross_neighbour_pixel_blend_defines.svh"

module cnpb_checker #(
    parameter int CHANNEL_BITS = cnpb_pkg::CHANNEL_BITS_DEF
) (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_stall,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic [CHANNEL_BITS-1:0]             red_out,
    input logic [CHANNEL_BITS-1:0]             green_out,
    input logic [CHANNEL_BITS-1:0]             blue_out,
    input logic [cnpb_pkg::POS_BITS-1:0]       out_row,
    input logic [cnpb_pkg::POS_BITS-1:0]       out_col,
    input logic                                last_of_run
);

    logic [3*CHANNEL_BITS+2*cnpb_pkg::POS_BITS:0] out_word;

    assign out_word = {red_out, green_out, blue_out, out_row, out_col, last_of_run};

    // hold a stalled output word
    `CNPB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word))

    // accepted word keeps the input stalled while its reads run
    `CNPB_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

    // a run with results still to come blocks new input words
    `CNPB_ASSERT_IMPLIES(a_run_holds_input, out_valid && !last_of_run, in_stall)

    // after a non-final result is taken the run is still in progress
    `CNPB_ASSERT_NEXT(a_run_continues, out_valid && !out_stall && !last_of_run, out_valid || in_stall)

endmodule

bind cross_neighbour_pixel_blend cnpb_checker #(
    .CHANNEL_BITS (CHANNEL_BITS)
) u_cnpb_checker (.*);
